FILE: rtl/ckame_pkg.sv
// ---------------------------------------------------------------------------
// ckame_pkg
// Shared types and constants of the color key alpha matte and erosion block.
// ---------------------------------------------------------------------------
package ckame_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MASK_COUNT_DEF = 5;
  localparam int MASK_SLOTS     = 5;
  localparam int MAX_HEIGHT     = 4096;
  localparam int ROW_W          = 12;
  localparam int PERCENT_MAX    = 100;
  localparam int RECIP_100      = 5243;
  localparam int RECIP_SHIFT    = 19;
  localparam int NO_MASK_DIFF   = 256;
  localparam int IN_DATA_W      = 160;
  localparam int OUT_DATA_W     = 32;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_LOW  = 3'd0,
    REG_DIFF_HIGH = 3'd1,
    REG_SHRINK    = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_DIVWAIT,
    ST_PLAN,
    ST_RADDR,
    ST_RDATA,
    ST_BL1,
    ST_BL2,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic       start;
    logic [15:0] num;
    logic [7:0] den;
  } div_req_t;

endpackage

FILE: rtl/ckame_lane.sv
// ---------------------------------------------------------------------------
// ckame_lane
// One mask lane: largest absolute channel difference between source and mask.
// ---------------------------------------------------------------------------
module ckame_lane (
  input  logic [23:0] src_rgb_i,
  input  logic [23:0] mask_rgb_i,
  output logic [7:0]  dk_o
);
  import ckame_pkg::*;

  logic [7:0] d [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (src_rgb_i[8*ch +: 8] > mask_rgb_i[8*ch +: 8]) begin
        d[ch] = src_rgb_i[8*ch +: 8] - mask_rgb_i[8*ch +: 8];
      end else begin
        d[ch] = mask_rgb_i[8*ch +: 8] - src_rgb_i[8*ch +: 8];
      end
    end
    dk_o = d[0];
    if (d[1] > dk_o) dk_o = d[1];
    if (d[2] > dk_o) dk_o = d[2];
  end

endmodule

FILE: rtl/ckame_merge.sv
// ---------------------------------------------------------------------------
// ckame_merge
// Minimum of the lane differences over the valid masks.
// ---------------------------------------------------------------------------
module ckame_merge #(
  parameter int MASK_COUNT = ckame_pkg::MASK_COUNT_DEF
) (
  input  logic [7:0]            dk_i [MASK_COUNT],
  input  logic [MASK_COUNT-1:0] en_i,
  output logic [8:0]            dmin_o
);
  import ckame_pkg::*;

  always_comb begin
    dmin_o = 9'(NO_MASK_DIFF);
    for (int k = 0; k < MASK_COUNT; k++) begin
      if (en_i[k] && ({1'b0, dk_i[k]} < dmin_o)) dmin_o = {1'b0, dk_i[k]};
    end
  end

endmodule

FILE: rtl/ckame_div.sv
// ---------------------------------------------------------------------------
// ckame_div
// Restoring divider, one quotient bit per cycle, 16 bit by 8 bit.
// ---------------------------------------------------------------------------
module ckame_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ckame_pkg::div_req_t  req_i,
  output logic                 done_o,
  output logic [7:0]           quo_o
);
  import ckame_pkg::*;

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [7:0]  rem_q, rem_d, den_q, den_d;
  logic [15:0] num_q, num_d;
  logic [8:0]  sh;
  logic        ge;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    sh     = {rem_q, num_q[15]};
    ge     = sh >= {1'b0, den_q};
    if (req_i.start) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = req_i.den;
      num_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = ge ? 8'(sh - {1'b0, den_q}) : sh[7:0];
      num_d = {num_q[14:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q[7:0];

endmodule

FILE: rtl/color_key_alpha_matte_erode.sv
// ---------------------------------------------------------------------------
// color_key_alpha_matte_erode
// Color key alpha matte over up to five masks with one 3x3 alpha erosion pass.
// ---------------------------------------------------------------------------
// One word is processed at a time. A pixel word is taken, runs through the
// mask lanes and the threshold decision and, when the difference falls
// between the thresholds, through the bit-serial divider; then its release
// is planned. A word that releases a pixel then reads the nine taps of the
// 3x3 window from the single-port line store (an address and a data step
// each), runs the blend multiplies and commits; one that releases nothing
// commits straight after the plan. A flush word goes straight to the
// release plan and releases a pixel only when one is ready. A
// result still waiting at the output holds the commit until it is taken.
// Output is registered, so a new word is taken while a result waits. Results
// lag the input by up to frame_width+1 pixels; send flush words after a frame
// to drain it. The line store needs no clearing after reset.
// ---------------------------------------------------------------------------
module color_key_alpha_matte_erode #(
  parameter int MAX_WIDTH  = ckame_pkg::MAX_WIDTH_DEF,
  parameter int MASK_COUNT = ckame_pkg::MASK_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // src_rgb, src_alpha, mask_rgb_0..4, mask_valid, zero pad
  input  logic [ckame_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_rgb, out_alpha
  output logic [ckame_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // end_of_row
  output logic                               m_axis_tlast,
  // end_of_frame
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [ckame_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ckame_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ckame_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(DEPTH) + 3;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  state_e state_q, state_d;

  logic [7:0]  diff_low_q;
  logic [8:0]  diff_high_q;
  logic [6:0]  shrink_q;
  logic [11:0] width_q;
  logic [12:0] height_q;

  logic        op_q;
  logic [23:0] rgb_q;
  logic [7:0]  a_q;
  logic [23:0] mask_q [MASK_COUNT];
  logic [MASK_COUNT-1:0] valid_q;

  logic [7:0]  dk [MASK_COUNT];
  logic [8:0]  dmin, dmin_q;
  logic [15:0] num_q;
  logic [7:0]  den_q, matte_q, matte_d, quo;
  logic        div_done;
  div_req_t    div_req;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_q;
  logic [AW-1:0] wp_q, rd_addr;
  logic [PW-1:0] pend_q, total_q;
  logic [CW-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  logic        rel_q, right_q, left_q, up_q, down_q, inc_q;
  logic [PW-1:0] dcen_q;
  logic [1:0]  dr_q, dx_q;
  logic        use_inc_q, allow_q;
  logic [7:0]  mn_q;
  logic [31:0] cen_q;
  logic [14:0] bl_q;
  logic [27:0] q_q;

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;

  logic [31:0] out_data_q;
  logic        out_valid_q, out_last_q, out_eof_q;

  // geometry
  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = 13'd1;
    else if (32'(height_q) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
    else h_eff = height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_low_q  <= '0;
      diff_high_q <= 9'h1FF;
      shrink_q    <= '0;
      width_q     <= 12'd640;
      height_q    <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DIFF_LOW:  diff_low_q  <= cfg_data_i[7:0];
        REG_DIFF_HIGH: diff_high_q <= cfg_data_i[8:0];
        REG_SHRINK:    shrink_q    <= cfg_data_i[6:0];
        REG_WIDTH:     width_q     <= cfg_data_i[11:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // mask lanes
  for (genvar k = 0; k < MASK_COUNT; k++) begin : g_lane
    ckame_lane u_lane (
      .src_rgb_i  (rgb_q),
      .mask_rgb_i (mask_q[k]),
      .dk_o       (dk[k])
    );
  end

  ckame_merge #(.MASK_COUNT(MASK_COUNT)) u_merge (
    .dk_i   (dk),
    .en_i   (valid_q),
    .dmin_o (dmin)
  );

  assign div_req.start = (state_q == ST_DIV);
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  ckame_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // threshold decision
  logic [7:0] hi8, lo8;
  logic       hi_neg;
  always_comb begin
    hi_neg = diff_high_q[8];
    hi8    = diff_high_q[7:0];
    lo8    = (diff_low_q > hi8) ? hi8 : diff_low_q;
  end

  // release plan
  logic [PW:0]   total_c;
  logic [WW:0]   col_p1, needed;
  logic [13:0]   row_p1;
  logic          right_c, left_c, up_c, down_c, rel_c;
  always_comb begin
    total_c = {1'b0, pend_q} + (PW+1)'(op_q == OP_PIXEL);
    col_p1  = (WW+1)'(col_q) + 1'b1;
    row_p1  = 14'(row_q) + 1'b1;
    right_c = col_p1 < (WW+1)'(w_eff);
    left_c  = col_q != '0;
    up_c    = row_q != '0;
    down_c  = row_p1 < 14'(h_eff);
    needed  = down_c ? (WW+1)'(w_eff) + (WW+1)'(right_c) : (WW+1)'(right_c);
    rel_c   = (total_c != '0) && (32'(total_c) - 1 >= 32'(needed));
  end

  // window address
  logic signed [SW-1:0] gap, tap;
  logic                 allow_c;
  always_comb begin
    gap = SW'(dcen_q);
    if (dr_q == 2'd0) gap = gap + SW'(w_eff);
    if (dr_q == 2'd2) gap = gap - SW'(w_eff);
    if (dx_q == 2'd0) gap = gap + SW'(1);
    if (dx_q == 2'd2) gap = gap - SW'(1);
    if (gap > SW'(DEPTH)) gap = SW'(DEPTH);
    tap = SW'(wp_q) - gap;
    if (tap < 0) tap = tap + SW'(DEPTH);
    rd_addr = AW'(tap);
    allow_c = !((dr_q == 2'd0) && !up_q) && !((dr_q == 2'd2) && !down_q) &&
              !((dx_q == 2'd0) && !left_q) && !((dx_q == 2'd2) && !right_q);
  end

  logic [31:0] tap_val, incoming;
  logic [7:0]  cen_a, rate, res;
  logic        out_free;
  assign incoming = inc_q ? {matte_q, rgb_q} : 32'd0;
  assign tap_val  = use_inc_q ? incoming : rd_q;
  assign cen_a    = cen_q[31:24];
  assign rate     = (shrink_q > 7'(PERCENT_MAX)) ? 8'(PERCENT_MAX) : {1'b0, shrink_q};
  assign res      = cen_a - q_q[RECIP_SHIFT +: 8];
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    matte_d = matte_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser[0] == OP_FLUSH) ? ST_PLAN : ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_MUL;
      ST_MUL: begin
        state_d = ST_PLAN;
        if (hi_neg || dmin_q > {1'b0, hi8}) matte_d = a_q;
        else if (dmin_q <= {1'b0, lo8}) matte_d = '0;
        else state_d = ST_DIV;
      end
      ST_DIV: state_d = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_done) begin
          matte_d = quo;
          state_d = ST_PLAN;
        end
      end
      ST_PLAN:  state_d = rel_c ? ST_RADDR : ST_COMMIT;
      ST_RADDR: state_d = ST_RDATA;
      ST_RDATA: state_d = (dr_q == 2'd2 && dx_q == 2'd2) ? ST_BL1 : ST_RADDR;
      ST_BL1:   state_d = ST_BL2;
      ST_BL2:   state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (!rel_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      wp_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_COMMIT && rel_q && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == ST_COMMIT && (!rel_q || out_free)) begin
        pend_q <= rel_q ? total_q - PW'(1) : total_q;
        if (inc_q) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
        if (rel_q) begin
          if (!right_q) begin
            col_q <= '0;
            row_q <= down_q ? ROW_W'(row_q + 1'b1) : '0;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tuser[0];
      rgb_q   <= s_axis_tdata[23:0];
      a_q     <= s_axis_tdata[31:24];
      valid_q <= s_axis_tdata[152 +: MASK_COUNT];
      for (int k = 0; k < MASK_COUNT; k++) mask_q[k] <= s_axis_tdata[32+24*k +: 24];
    end
    if (state_q == ST_IDLE) matte_q <= '0;
    else matte_q <= matte_d;
    dmin_q <= dmin;
    num_q  <= 16'(a_q * 8'(dmin_q - {1'b0, lo8}));
    den_q  <= hi8 - lo8;
    if (state_q == ST_PLAN) begin
      rel_q   <= rel_c;
      total_q <= PW'(total_c);
      inc_q   <= (op_q == OP_PIXEL);
      dcen_q  <= pend_q;
      right_q <= right_c;
      left_q  <= left_c;
      up_q    <= up_c;
      down_q  <= down_c;
      dr_q    <= '0;
      dx_q    <= '0;
      mn_q    <= 8'hFF;
    end
    if (state_q == ST_RADDR) begin
      rd_q      <= mem[rd_addr];
      use_inc_q <= gap <= 0;
      allow_q   <= allow_c;
    end
    if (state_q == ST_RDATA) begin
      if (allow_q && tap_val[31:24] < mn_q) mn_q <= tap_val[31:24];
      if (dr_q == 2'd1 && dx_q == 2'd1) cen_q <= tap_val;
      if (dx_q == 2'd2) begin
        dx_q <= '0;
        dr_q <= dr_q + 1'b1;
      end else begin
        dx_q <= dx_q + 1'b1;
      end
    end
    bl_q <= 15'((cen_a - mn_q) * rate);
    q_q  <= 28'(bl_q * 13'(RECIP_100));
    if (state_q == ST_COMMIT && (!rel_q || out_free)) begin
      if (inc_q) mem[wp_q] <= incoming;
      if (rel_q) begin
        out_data_q <= {res, cen_q[23:0]};
        out_last_q <= !right_q;
        out_eof_q  <= !right_q && !down_q;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_eof_q;

endmodule

FILE: rtl/ckame_chk.sv
// ---------------------------------------------------------------------------
// ckame_chk
// Port-level checks of the color key matte block, bound to the top level.
// ---------------------------------------------------------------------------
module ckame_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ckame_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic [0:0]                       m_axis_tuser
);
  import ckame_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a word");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("frame end without row end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_one_result_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid || s_axis_tready ||
      $past(!s_axis_tready))
    else $error("result produced without input word");

endmodule

bind color_key_alpha_matte_erode ckame_chk u_ckame_chk (.*);
